// ===== rtl/core/tbrcs_pkg.sv =====
// package for the table row/column sum block
// widths, register indexes, entry kinds, controller states and the cell control word
// no dependencies
package tbrcs_pkg;

    localparam int ELEM_W     = 16;
    localparam int SUM_W      = 32;
    localparam int ROW_W      = 11;
    localparam int COL_W      = 6;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam int MAX_COLS_DEF = 32;
    localparam int MAX_ROWS     = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd1;

    localparam logic [KIND_W-1:0] KIND_ELEM  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ROW   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COL   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_GRAND = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_COL,
        ST_GRAND
    } t_state;

    typedef struct packed {
        logic clear;
        logic add;
        logic shift;
        logic wrap;
    } t_cell_ctl;

endpackage

// ===== rtl/core/tbrcs_if.sv =====
// valid/ready channels of the table row/column sum block
// depends on tbrcs_pkg
interface tbrcs_in_if import tbrcs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink (input valid, input element_value, output ready);
endinterface

interface tbrcs_out_if import tbrcs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] out_value;
    logic [KIND_W-1:0]       entry_kind;
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        out_col;
    logic                    last_of_run;

    modport source (output valid, output out_value, output entry_kind, output out_row,
                    output out_col, output last_of_run, input ready);
    modport sink (input valid, input out_value, input entry_kind, input out_row,
                  input out_col, input last_of_run, output ready);
endinterface

// ===== rtl/core/table_row_column_sums.sv =====
// top level of the table row/column sum block
// depends on tbrcs_pkg, tbrcs_if, tbrcs_cell and tbrcs_ctrl
//
// usage:
//   elements of a num_rows x num_cols table arrive on i_elem in row-major
//   order, one 16-bit signed word per handshake. every element comes back on
//   o_res as an element copy, each row's last element is followed by its row
//   sum, and the table's last element by all column sums, left to right, and
//   the grand total. last_of_run marks the final word caused by an element.
//   i_cfg_we/i_cfg_idx/i_cfg_data set num_rows (index 0) and num_cols
//   (index 1); any write abandons the table in progress.
// timing:
//   an element that ends a row is followed by its row sum, and the table's last
//   element then by the column sums and the grand total; the column sums shift
//   out of the cell chain one cell per cycle unless the receiver stalls. an
//   element's copy shows on o_res in the cycle after the element is taken.
//   a single output register parts the channels; while the receiver stalls
//   with a word waiting, no further element or word is taken.
//   reset sets both counts to 1 and clears every sum and position.
module table_row_column_sums import tbrcs_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tbrcs_in_if.sink              i_elem,
    tbrcs_out_if.source           o_res
);

    logic [ROW_W-1:0] r_num_rows;
    logic [COL_W-1:0] r_num_cols;
    logic [ROW_W-1:0] rows_eff;
    logic [COL_W-1:0] cols_eff;
    t_cell_ctl        ctl;
    logic [SUM_W-1:0] value;
    logic [SUM_W-1:0] acc [MAX_COLS+1];
    logic             tok [MAX_COLS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= ROW_W'(1);
            r_num_cols <= COL_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NUM_ROWS: r_num_rows <= i_cfg_data[ROW_W-1:0];
                REG_NUM_COLS: r_num_cols <= i_cfg_data[COL_W-1:0];
                default: begin
                    r_num_rows <= r_num_rows;
                end
            endcase
        end
    end

    always_comb begin
        if (r_num_rows == '0) begin
            rows_eff = ROW_W'(1);
        end else if (32'(r_num_rows) > MAX_ROWS) begin
            rows_eff = ROW_W'(MAX_ROWS);
        end else begin
            rows_eff = r_num_rows;
        end
        if (r_num_cols == '0) begin
            cols_eff = COL_W'(1);
        end else if (32'(r_num_cols) > MAX_COLS) begin
            cols_eff = COL_W'(MAX_COLS);
        end else begin
            cols_eff = r_num_cols;
        end
    end

    tbrcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (i_cfg_we),
        .i_rows     (rows_eff),
        .i_cols     (cols_eff),
        .i_head_acc (acc[0]),
        .o_ctl      (ctl),
        .o_value    (value),
        .i_elem     (i_elem),
        .o_res      (o_res)
    );

    assign acc[MAX_COLS] = '0;
    assign tok[MAX_COLS] = 1'b0;

    for (genvar k = 0; k < MAX_COLS; k++) begin : g_cell
        tbrcs_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_home     ((k == 0) ? 1'b1 : 1'b0),
            .i_tok_prev ((k == 0) ? tok[MAX_COLS] : tok[(k == 0) ? 0 : k-1]),
            .i_value    (value),
            .i_acc_next (acc[k+1]),
            .o_tok      (tok[k]),
            .o_acc      (acc[k])
        );
    end

endmodule

// ===== rtl/core/tbrcs_cell.sv =====
// one column cell: column accumulator plus the column token
// depends on tbrcs_pkg
module tbrcs_cell import tbrcs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic             i_home,
    input  logic             i_tok_prev,
    input  logic [SUM_W-1:0] i_value,
    input  logic [SUM_W-1:0] i_acc_next,
    output logic             o_tok,
    output logic [SUM_W-1:0] o_acc
);

    logic             r_tok;
    logic             n_tok;
    logic [SUM_W-1:0] r_acc;
    logic [SUM_W-1:0] n_acc;

    always_comb begin
        n_tok = r_tok;
        n_acc = r_acc;
        if (i_ctl.clear) begin
            n_tok = i_home;
            n_acc = '0;
        end else if (i_ctl.add) begin
            n_tok = i_ctl.wrap ? i_home : i_tok_prev;
            if (r_tok) begin
                n_acc = r_acc + i_value;
            end
        end else if (i_ctl.shift) begin
            n_acc = i_acc_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= i_home;
            r_acc <= '0;
        end else begin
            r_tok <= n_tok;
            r_acc <= n_acc;
        end
    end

    assign o_tok = r_tok;
    assign o_acc = r_acc;

endmodule

// ===== rtl/core/tbrcs_ctrl.sv =====
// sequencer: positions, row and grand sums, output word register
// depends on tbrcs_pkg and tbrcs_if
module tbrcs_ctrl import tbrcs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic [ROW_W-1:0] i_rows,
    input  logic [COL_W-1:0] i_cols,
    input  logic [SUM_W-1:0] i_head_acc,
    output t_cell_ctl        o_ctl,
    output logic [SUM_W-1:0] o_value,
    tbrcs_in_if.sink         i_elem,
    tbrcs_out_if.source      o_res
);

    t_state            r_state;
    t_state            n_state;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [SUM_W-1:0]  r_row_acc;
    logic [SUM_W-1:0]  r_grand;

    logic              r_ov;
    logic [SUM_W-1:0]  r_ovalue;
    logic [KIND_W-1:0] r_okind;
    logic [ROW_W-1:0]  r_orow;
    logic [COL_W-1:0]  r_ocol;
    logic              r_olast;

    logic              load_ok;
    logic              accept;
    logic              load;
    logic              col_last;
    logic              row_last;
    logic [SUM_W-1:0]  value;
    logic [SUM_W-1:0]  w_value;
    logic [KIND_W-1:0] w_kind;
    logic [ROW_W-1:0]  w_row;
    logic [COL_W-1:0]  w_col;
    logic              w_last;

    assign value    = {{(SUM_W-ELEM_W){i_elem.element_value[ELEM_W-1]}}, i_elem.element_value};
    assign load_ok  = !r_ov || o_res.ready;
    assign col_last = (r_col == i_cols - COL_W'(1));
    assign row_last = (r_row == i_rows - ROW_W'(1));
    assign accept   = i_elem.valid && i_elem.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (accept && col_last) n_state = ST_ROW;
            ST_ROW:   if (load_ok) n_state = row_last ? ST_COL : ST_IDLE;
            ST_COL:   if (load_ok && col_last) n_state = ST_GRAND;
            ST_GRAND: if (load_ok) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_elem.ready = 1'b0;
        load         = 1'b0;
        o_ctl        = '0;
        w_value      = value;
        w_kind       = KIND_ELEM;
        w_row        = r_row;
        w_col        = r_col;
        w_last       = !col_last;
        case (r_state)
            ST_IDLE: begin
                i_elem.ready = load_ok;
                load         = i_elem.valid && load_ok;
                o_ctl.add    = i_elem.valid && load_ok;
                o_ctl.wrap   = col_last;
            end
            ST_ROW: begin
                load    = load_ok;
                w_value = r_row_acc;
                w_kind  = KIND_ROW;
                w_col   = i_cols;
                w_last  = !row_last;
            end
            ST_COL: begin
                load        = load_ok;
                o_ctl.shift = load_ok;
                w_value     = i_head_acc;
                w_kind      = KIND_COL;
                w_row       = i_rows;
                w_last      = 1'b0;
            end
            ST_GRAND: begin
                load        = load_ok;
                o_ctl.clear = load_ok;
                w_value     = r_grand;
                w_kind      = KIND_GRAND;
                w_row       = i_rows;
                w_col       = i_cols;
                w_last      = 1'b1;
            end
            default: begin
                load = 1'b0;
            end
        endcase
        if (i_clear) begin
            o_ctl.clear = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_state   <= ST_IDLE;
            r_row     <= '0;
            r_col     <= '0;
            r_row_acc <= '0;
            r_grand   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_row_acc <= r_row_acc + value;
                        r_grand   <= r_grand + value;
                        r_col     <= col_last ? '0 : r_col + COL_W'(1);
                    end
                end
                ST_ROW: begin
                    if (load_ok) begin
                        r_row_acc <= '0;
                        r_row     <= row_last ? '0 : r_row + ROW_W'(1);
                    end
                end
                ST_COL: begin
                    if (load_ok) begin
                        r_col <= col_last ? '0 : r_col + COL_W'(1);
                    end
                end
                ST_GRAND: begin
                    if (load_ok) begin
                        r_grand <= '0;
                    end
                end
                default: begin
                    r_col <= '0;
                end
            endcase
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ovalue <= w_value;
            r_okind  <= w_kind;
            r_orow   <= w_row;
            r_ocol   <= w_col;
            r_olast  <= w_last;
        end
    end

    assign o_value           = value;
    assign o_res.valid       = r_ov;
    assign o_res.out_value   = r_ovalue;
    assign o_res.entry_kind  = r_okind;
    assign o_res.out_row     = r_orow;
    assign o_res.out_col     = r_ocol;
    assign o_res.last_of_run = r_olast;

endmodule

// ===== rtl/core/tbrcs_checker.sv =====
// port-level checks for the table row/column sum block
// depends on tbrcs_pkg; bound to table_row_column_sums
module tbrcs_checker import tbrcs_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [SUM_W-1:0] i_out_value,
    input logic [KIND_W-1:0]       i_entry_kind,
    input logic [ROW_W-1:0]        i_out_row,
    input logic [COL_W-1:0]        i_out_col,
    input logic                    i_last_of_run
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value)
            && $stable(i_entry_kind) && $stable(i_out_row) && $stable(i_out_col))
        else $error("stalled output word changed");

    a_elem_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid && i_entry_kind == KIND_ELEM)
        else $error("accepted element not echoed next cycle");

    a_grand_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_entry_kind == KIND_GRAND |-> i_last_of_run)
        else $error("grand total not marked last");

    a_col_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_entry_kind == KIND_COL |-> !i_last_of_run)
        else $error("column sum marked last");

endmodule

bind table_row_column_sums tbrcs_checker u_tbrcs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_elem.valid),
    .i_in_ready    (i_elem.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_value   (o_res.out_value),
    .i_entry_kind  (o_res.entry_kind),
    .i_out_row     (o_res.out_row),
    .i_out_col     (o_res.out_col),
    .i_last_of_run (o_res.last_of_run)
);

// ===== tb/sv/table_row_column_sums_tb.sv =====
`timescale 1ns / 100ps
// testbench for table_row_column_sums: streams tables of signed elements and checks every
// element copy, row sum, column sum and grand total against an in-bench prediction
// depends on tbrcs_pkg, tbrcs_if and the table_row_column_sums rtl
module table_row_column_sums_tb;
    import tbrcs_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int LIMIT_NS      = 8_000_000;
    localparam int SETTLE_CYCLES = MAX_COLS_DEF + 4;
    localparam int IDLE_PCT      = 9;

    typedef struct packed {
        logic [SUM_W-1:0]  value;
        logic [KIND_W-1:0] kind;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              last;
    } t_aug_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tbrcs_in_if  elem_if ();
    tbrcs_out_if res_if ();

    table_row_column_sums dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_elem     (elem_if),
        .o_res      (res_if)
    );

    // predicted block state
    logic [ROW_W-1:0] rows_setting;
    logic [COL_W-1:0] cols_setting;
    logic [SUM_W-1:0] col_sums [MAX_COLS_DEF];
    logic [SUM_W-1:0] row_sum;
    logic [SUM_W-1:0] grand_sum;
    int unsigned      row_pos;
    int unsigned      col_pos;

    t_aug_word                expected_words [$];
    logic signed [ELEM_W-1:0] pending_elems [$];

    logic elem_taken = 1'b0;
    logic no_gaps    = 1'b0;
    int   mismatches    = 0;
    int   words_checked = 0;
    int   elems_queued  = 0;
    int   elems_taken   = 0;
    int   tables_done   = 0;

    always begin
        #HALF_PERIOD;
        i_clk = 1'b1;
        #HALF_PERIOD;
        i_clk = 1'b0;
    end

    initial begin
        #(LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

    function automatic int unsigned eff_rows();
        if (rows_setting == 0) return 1;
        if (rows_setting > MAX_ROWS) return MAX_ROWS;
        return rows_setting;
    endfunction

    function automatic int unsigned eff_cols();
        if (cols_setting == 0) return 1;
        if (cols_setting > MAX_COLS_DEF) return MAX_COLS_DEF;
        return cols_setting;
    endfunction

    task automatic clear_sums();
        for (int j = 0; j < MAX_COLS_DEF; j++) col_sums[j] = '0;
        row_sum   = '0;
        grand_sum = '0;
        row_pos   = 0;
        col_pos   = 0;
    endtask

    task automatic predict_augmented(input logic signed [ELEM_W-1:0] elem);
        int unsigned      rows;
        int unsigned      cols;
        int unsigned      r;
        int unsigned      c;
        logic [SUM_W-1:0] v;
        t_aug_word        w;
        rows = eff_rows();
        cols = eff_cols();
        r = (row_pos >= rows) ? rows - 1 : row_pos;
        c = (col_pos >= cols) ? cols - 1 : col_pos;
        v = {{(SUM_W-ELEM_W){elem[ELEM_W-1]}}, elem};
        expected_words.push_back('{v, KIND_ELEM, ROW_W'(r), COL_W'(c), 1'b0});
        row_sum   += v;
        col_sums[c] += v;
        grand_sum += v;
        if (c + 1 < cols) begin
            col_pos = c + 1;
            row_pos = r;
        end else begin
            expected_words.push_back('{row_sum, KIND_ROW, ROW_W'(r), COL_W'(cols), 1'b0});
            row_sum = '0;
            col_pos = 0;
            if (r + 1 < rows) begin
                row_pos = r + 1;
            end else begin
                for (int j = 0; j < cols; j++)
                    expected_words.push_back('{col_sums[j], KIND_COL, ROW_W'(rows),
                                               COL_W'(j), 1'b0});
                expected_words.push_back('{grand_sum, KIND_GRAND, ROW_W'(rows),
                                           COL_W'(cols), 1'b0});
                tables_done++;
                clear_sums();
            end
        end
        w = expected_words.pop_back();
        w.last = 1'b1;
        expected_words.push_back(w);
    endtask

    task automatic check_field(input string name, input logic [SUM_W-1:0] want,
                               input logic [SUM_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_aug_word want;
        elem_taken <= i_rst_n && elem_if.valid && elem_if.ready;
        if (i_rst_n && elem_if.valid && elem_if.ready) begin
            predict_augmented(elem_if.element_value);
            elems_taken++;
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            words_checked++;
            if (expected_words.size() == 0) begin
                $error("word with none expected: value %0h kind %0d", res_if.out_value,
                       res_if.entry_kind);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                check_field("out_value", want.value, res_if.out_value);
                check_field("entry_kind", SUM_W'(want.kind), SUM_W'(res_if.entry_kind));
                check_field("out_row", SUM_W'(want.row), SUM_W'(res_if.out_row));
                check_field("out_col", SUM_W'(want.col), SUM_W'(res_if.out_col));
                check_field("last_of_run", SUM_W'(want.last), SUM_W'(res_if.last_of_run));
            end
        end
    end

    always @(negedge i_clk) begin : driver
        if (!elem_if.valid || elem_taken) begin
            if (pending_elems.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
                elem_if.valid         <= 1'b1;
                elem_if.element_value <= pending_elems.pop_front();
            end else begin
                elem_if.valid         <= 1'b0;
                elem_if.element_value <= ELEM_W'($urandom);
            end
        end
        res_if.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic logic [ELEM_W-1:0] random_elem();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return '0;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    task automatic queue_elem(input logic [ELEM_W-1:0] v);
        pending_elems.push_back(v);
        elems_queued++;
    endtask

    // wait until every queued element is taken and every predicted word has come back
    task automatic drain();
        while (elems_taken != elems_queued || expected_words.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        i_cfg_data <= CFG_DATA_W'($urandom);
        if (idx == REG_NUM_ROWS) rows_setting = data[ROW_W-1:0];
        else cols_setting = data[COL_W-1:0];
        clear_sums();
    endtask

    task automatic set_table(input logic [CFG_DATA_W-1:0] rows_data,
                             input logic [CFG_DATA_W-1:0] cols_data);
        drain();
        write_reg(REG_NUM_ROWS, rows_data);
        write_reg(REG_NUM_COLS, cols_data);
    endtask

    initial begin : stimulus
        int unsigned random_items;
        int unsigned count;
        int unsigned pause_at;
        int unsigned tab;
        logic [CFG_DATA_W-1:0] rows_data;
        logic [CFG_DATA_W-1:0] cols_data;
        elem_if.valid         = 1'b0;
        elem_if.element_value = '0;
        res_if.ready          = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = REG_NUM_ROWS;
        i_cfg_data            = '0;
        i_rst_n               = 1'b0;
        rows_setting          = 1;
        cols_setting          = 1;
        clear_sums();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset sizes are one by one
        queue_elem(16'h8000);
        queue_elem(16'h7fff);
        queue_elem(16'h0000);

        set_table(2, 3);
        repeat (3) queue_elem(16'h7fff);
        repeat (2) queue_elem(16'h8000);
        queue_elem(16'hffff);

        // partial table abandoned by a write of the same value
        set_table(3, 2);
        queue_elem(16'h0001);
        queue_elem(16'hffff);
        queue_elem(16'h7fff);
        drain();
        write_reg(REG_NUM_COLS, 2);
        for (int i = 0; i < 6; i++) queue_elem(random_elem());

        // zero counts act as one
        set_table(0, 0);
        queue_elem(16'h8000);

        // largest row count, upper data bits set on the column write
        set_table(11'd1024, 11'h7c4);
        for (int i = 0; i < 4; i++) queue_elem(random_elem());

        set_table(11'h7ff, 11'h03f);
        queue_elem(16'h5a5a);
        queue_elem(16'ha5a5);

        random_items = 0;
        tab = 0;
        while (random_items < 45 || tab < 5) begin
            rows_data = ($urandom_range(9) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 5));
            cols_data = {5'($urandom), 6'($urandom_range(0, 8))};
            if ($urandom_range(7) == 0) begin
                rows_data = CFG_DATA_W'(1);
                cols_data = {5'($urandom), 6'($urandom_range(9, 63))};
            end
            set_table(rows_data, cols_data);
            count = eff_rows() * eff_cols();
            if (count > 1 && $urandom_range(4) == 0) count = $urandom_range(1, count - 1);
            pause_at = (tab == 1) ? count / 2 : count;
            no_gaps = (tab >= 2 && tab <= 4);
            for (int unsigned i = 0; i < count; i++) begin
                if (i == pause_at) drain();
                queue_elem(random_elem());
            end
            random_items += count;
            tab++;
        end
        no_gaps = 1'b0;

        // clamped column count, widest table with extreme sums
        set_table(1, 11'h03f);
        for (int i = 0; i < MAX_COLS_DEF; i++) queue_elem(16'h7fff);

        drain();
        $display("run covered %0d elements and %0d complete tables, %0d result words checked",
                 elems_taken, tables_done, words_checked);
        $display("sizes from 1x1 to a clamped 1x32, zero and oversized counts, aborted tables");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
